@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checksum rtl
// every check samples on the rising clock and is off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property that must hold on every clock
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen on a clock
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ hw/rtl/gbc_pkg.sv @@
// constants and field arithmetic for the gf(32) bch checksum unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

   localparam int SYM_W = 5;
   // generator multiples kept: times 1, 2, 4, 8, 16
   localparam int MULT_COUNT = 5;
   localparam logic [SYM_W-1:0] FIELD_REDUCE = 5'h09;

   typedef logic [SYM_W-1:0] symbol_type;

   // multiply one gf(32) element by two
   function automatic symbol_type gf_times_two(input symbol_type c);
      gf_times_two = {c[SYM_W-2:0], 1'b0} ^ (c[SYM_W-1] ? FIELD_REDUCE : '0);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gbc_req_if.sv @@
// input channel of the checksum unit: one symbol per beat
// depends on gbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gbc_req_if
   import gbc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   symbol_type symbol;
   logic       last_symbol;

   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gbc_rsp_if.sv @@
// result channel of the checksum unit: one checksum per message
// width of the checksum follows the number of check symbols
`timescale 1ns / 1ps
`default_nettype none

interface gbc_rsp_if #(
   parameter int CHECK_BITS = 30
) ();
   logic                  valid;
   logic                  ready;
   logic [CHECK_BITS-1:0] checksum;
   logic                  short_message;

   modport source (output valid, output checksum, output short_message, input ready);
   modport sink   (input valid, input checksum, input short_message, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gf32_bch_checksum_unit.sv @@
// gf(32) bch checksum unit: top level with input stage, checksum state and result register
// depends on gbc_pkg, gbc_req_if, gbc_rsp_if, gbc_gen_table and assert_macros.svh
//
// usage:
//   req_chan carries one 5-bit symbol per beat, with last_symbol marking the end of a message.
//   rsp_chan carries one beat per message: the checksum and a short_message flag that is set
//   when the message had fewer than CHECK_SYMBOLS symbols.
//   csr_write_en / csr_write_data load the generator; write it only while no message is
//   in flight. the generator multiples are ready on the cycle after the write.
//   throughput is one symbol per cycle while no last symbol waits on the result register;
//   the remainder update is combinational. a last symbol's beat passes the input register,
//   then the remainder update into the result register, before its rsp beat.
//   when rsp_chan stalls, symbols that are not last keep flowing; a last symbol waits in the
//   input register until the result register is free, and req_chan.ready drops behind it.
//   reset clears the generator to zero, the checksum state and both valid flags.
`include "assert_macros.svh"
`timescale 1ns / 1ps
`default_nettype none

module gf32_bch_checksum_unit
   import gbc_pkg::*;
#(
   parameter int CHECK_SYMBOLS = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gbc_req_if.sink                             req_chan,
   gbc_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_write_en,
   input  wire logic [SYM_W*CHECK_SYMBOLS-1:0] csr_write_data
);

   localparam int CHECK_BITS = SYM_W * CHECK_SYMBOLS;
   localparam int HELD_W     = $clog2(CHECK_SYMBOLS + 1);
   localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(CHECK_SYMBOLS);
   localparam logic [HELD_W-1:0] HELD_NEAR = HELD_W'(CHECK_SYMBOLS - 1);

   logic [CHECK_BITS-1:0] mult [MULT_COUNT];

   gbc_gen_table #(
      .CHECK_SYMBOLS (CHECK_SYMBOLS)
   ) u_gen_table (
      .clock      (clock),
      .reset      (reset),
      .write_en   (csr_write_en),
      .write_data (csr_write_data),
      .mult_o     (mult)
   );

   // input register
   logic       in_valid_ff, in_valid_in;
   symbol_type in_symbol_ff;
   logic       in_last_ff;

   // checksum state
   logic [CHECK_BITS-1:0] rem_ff, rem_in;
   logic [CHECK_BITS-1:0] delay_ff, delay_in;
   logic [HELD_W-1:0]     held_ff, held_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [CHECK_BITS-1:0] out_checksum_ff;
   logic                  out_short_ff;

   logic                  step_go;
   logic                  req_take;
   logic                  full;
   symbol_type            err_sym;
   logic [CHECK_BITS-1:0] rem_step;
   logic [CHECK_BITS-1:0] delay_step;
   logic [CHECK_BITS-1:0] checksum_next;
   logic                  short_next;

   // a last symbol may only move on when the result register can take it
   assign step_go  = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || step_go;

   assign full    = (held_ff == HELD_FULL);
   assign err_sym = rem_ff[CHECK_BITS-1 -: SYM_W] ^ delay_ff[CHECK_BITS-1 -: SYM_W];

   always_comb begin
      rem_step = {rem_ff[CHECK_BITS-SYM_W-1:0], {SYM_W{1'b0}}};
      for (int i = 0; i < MULT_COUNT; i++) begin
         if (err_sym[i]) begin
            rem_step = rem_step ^ mult[i];
         end
      end
      if (!full) begin
         rem_step = rem_ff;
      end
   end

   assign delay_step    = {delay_ff[CHECK_BITS-SYM_W-1:0], in_symbol_ff};
   assign checksum_next = rem_step ^ delay_step;
   assign short_next    = (held_ff < HELD_NEAR);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end

      rem_in   = rem_ff;
      delay_in = delay_ff;
      held_in  = held_ff;
      if (step_go) begin
         if (in_last_ff) begin
            rem_in   = '0;
            delay_in = '0;
            held_in  = '0;
         end else begin
            rem_in   = rem_step;
            delay_in = delay_step;
            held_in  = full ? held_ff : held_ff + HELD_W'(1);
         end
      end

      out_valid_in = out_valid_ff;
      if (step_go && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
         delay_ff     <= '0;
         held_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
         delay_ff     <= delay_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_symbol_ff <= req_chan.symbol;
         in_last_ff   <= req_chan.last_symbol;
      end
      if (step_go && in_last_ff) begin
         out_checksum_ff <= checksum_next;
         out_short_ff    <= short_next;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.checksum      = out_checksum_ff;
   assign rsp_chan.short_message = out_short_ff;

   `ASSERT_NEVER(held_in_range, held_ff > HELD_FULL, "held count above check symbols")
   `ASSERT_CLK(rem_zero_until_full, !full |-> rem_ff == '0, "remainder set before delay line full")
   `ASSERT_CLK(clear_after_last, step_go && in_last_ff |=> held_ff == '0 && delay_ff == '0,
      "state not cleared after last symbol")
   `ASSERT_CLK(result_held_in_stall, out_valid_ff && !rsp_chan.ready |=>
      out_valid_ff && $stable(out_checksum_ff), "pending result lost during stall")

endmodule

`default_nettype wire

@@ hw/rtl/gbc_gen_table.sv @@
// generator register and its precomputed multiples by 1, 2, 4, 8 and 16
// depends on gbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbc_gen_table
   import gbc_pkg::*;
#(
   parameter int CHECK_SYMBOLS = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            write_en,
   input  wire logic [SYM_W*CHECK_SYMBOLS-1:0]  write_data,
   output logic      [SYM_W*CHECK_SYMBOLS-1:0]  mult_o [MULT_COUNT]
);

   localparam int CHECK_BITS = SYM_W * CHECK_SYMBOLS;

   logic [CHECK_BITS-1:0] mult_ff [MULT_COUNT];
   logic [CHECK_BITS-1:0] mult_in [MULT_COUNT];

   // each multiple doubles every coefficient of the one before
   always_comb begin
      mult_in[0] = write_data;
      for (int i = 1; i < MULT_COUNT; i++) begin
         for (int j = 0; j < CHECK_SYMBOLS; j++) begin
            mult_in[i][j*SYM_W +: SYM_W] = gf_times_two(mult_in[i-1][j*SYM_W +: SYM_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MULT_COUNT; i++) begin
            mult_ff[i] <= '0;
         end
      end else if (write_en) begin
         mult_ff <= mult_in;
      end
   end

   assign mult_o = mult_ff;

endmodule

`default_nettype wire

@@ bench/gf32_bch_checksum_unit_tb.sv @@
// self-checking bench for the gf(32) bch checksum unit: directed table, then random messages
// under several generators, each checksum checked against a table value or a local predictor
// depends on gbc_pkg, gbc_req_if, gbc_rsp_if and gf32_bch_checksum_unit
`timescale 1ns / 1ps

module gf32_bch_checksum_unit_tb;
   import gbc_pkg::*;

   localparam int CHECK_SYMBOLS = 6;
   localparam int CHECK_BITS    = SYM_W * CHECK_SYMBOLS;
   localparam int BASE_BITS     = SYM_W * (CHECK_SYMBOLS - 1);
   localparam int PHASE_ITEMS   = 72;
   localparam int MAX_GAP       = 18;

   typedef logic [CHECK_BITS-1:0] check_word_type;

   typedef struct packed {
      check_word_type checksum;
      logic           short_message;
   } checksum_result_type;

   typedef struct packed {
      symbol_type     symbol;
      logic           last_symbol;
      logic           fixed;
      check_word_type checksum;
      logic           short_message;
   } directed_row_type;

   // with the generator at zero the checksum is just the held symbols
   localparam directed_row_type DIRECTED [21] = '{
      '{5'd31, 1'b1, 1'b1, 30'h0000001f, 1'b1},
      '{5'd0,  1'b1, 1'b1, 30'h00000000, 1'b1},
      '{5'd1,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd2,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd3,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd4,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd5,  1'b1, 1'b1, 30'h00110c85, 1'b1},
      '{5'd31, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b1, 1'b1, 30'h3fffffff, 1'b0},
      '{5'd16, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd0,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd8,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd1,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd4,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd2,  1'b0, 1'b0, 30'h0, 1'b0},
      '{5'd31, 1'b1, 1'b0, 30'h0, 1'b0}
   };

   logic           clock;
   logic           reset;
   logic           csr_write_en;
   check_word_type csr_write_data;

   gbc_req_if                         req_chan ();
   gbc_rsp_if #(.CHECK_BITS(CHECK_BITS)) rsp_chan ();

   gf32_bch_checksum_unit #(.CHECK_SYMBOLS(CHECK_SYMBOLS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   check_word_type gen_word;
   check_word_type remainder_word;
   check_word_type held_symbols;
   int unsigned    held_count;

   checksum_result_type pending_sums [$];
   int                  error_count = 0;
   int                  rsp_hold    = 0;
   bit                  src_quiet   = 0;
   bit                  snk_quiet   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Some tests failed");
      $finish;
   end

   // every coefficient of a packed word times two in gf(32)
   function automatic check_word_type gf_word_double(input check_word_type word);
      check_word_type out;
      symbol_type     c;
      out = '0;
      for (int j = 0; j < CHECK_SYMBOLS; j++) begin
         c = word[SYM_W*j +: SYM_W];
         out[SYM_W*j +: SYM_W] = {c[3:0], 1'b0} ^ (c[4] ? 5'h09 : 5'h00);
      end
      return out;
   endfunction

   task automatic checksum_advance(input symbol_type sym, input logic last,
                                   output bit got, output checksum_result_type res);
      symbol_type     pushed;
      symbol_type     e;
      check_word_type mult;
      got = 1'b0;
      res = '0;
      if (held_count >= CHECK_SYMBOLS) begin
         pushed = held_symbols[CHECK_BITS-1 -: SYM_W];
         e = remainder_word[CHECK_BITS-1 -: SYM_W] ^ pushed;
         mult = gen_word;
         remainder_word = {remainder_word[BASE_BITS-1:0], {SYM_W{1'b0}}};
         for (int i = 0; i < SYM_W; i++) begin
            if (e[i]) remainder_word ^= mult;
            mult = gf_word_double(mult);
         end
      end else begin
         held_count++;
      end
      held_symbols = {held_symbols[BASE_BITS-1:0], sym};
      if (last) begin
         got = 1'b1;
         res.checksum = remainder_word ^ held_symbols;
         res.short_message = (held_count < CHECK_SYMBOLS);
         remainder_word = '0;
         held_symbols = '0;
         held_count = 0;
      end
   endtask

   task automatic send_symbol(input symbol_type sym, input logic last, input logic fixed,
                              input checksum_result_type fixed_res);
      int                  gap;
      bit                  got;
      checksum_result_type res;
      gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.symbol      = sym;
      req_chan.last_symbol = last;
      do @(posedge clock); while (!req_chan.ready);
      checksum_advance(sym, last, got, res);
      if (got) pending_sums.insert(pending_sums.size(), fixed ? fixed_res : res);
   endtask

   // drain all results, then let the pipeline empty out
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_generator(input check_word_type value);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en   = 1'b0;
      gen_word = value;
      repeat (2) @(posedge clock);
   endtask

   function automatic symbol_type pick_symbol();
      case ($urandom_range(0, 7))
         0:       return 5'd0;
         1:       return 5'd31;
         default: return symbol_type'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return $urandom_range(1, CHECK_SYMBOLS - 1);
      if (r == 3) return CHECK_SYMBOLS;
      if (r == 4) return CHECK_SYMBOLS + 1;
      return $urandom_range(CHECK_SYMBOLS + 2, 24);
   endfunction

   // result side: compare each beat, then draw the stall before the next one
   always @(posedge clock) begin
      checksum_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected result beat: checksum %h short_message %b",
                   rsp_chan.checksum, rsp_chan.short_message);
            error_count++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_chan.checksum !== want.checksum) begin
               $error("checksum: expected %h, actual %h", want.checksum, rsp_chan.checksum);
               error_count++;
            end
            if (rsp_chan.short_message !== want.short_message) begin
               $error("short_message: expected %b, actual %b",
                      want.short_message, rsp_chan.short_message);
               error_count++;
            end
         end
         rsp_hold = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      check_word_type      phase_gens [6];
      int                  sent;
      int                  len;
      checksum_result_type none;

      none = '0;
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_write_data       = '0;
      req_chan.valid       = 1'b0;
      req_chan.symbol      = '0;
      req_chan.last_symbol = 1'b0;
      rsp_chan.ready       = 1'b0;
      gen_word       = '0;
      remainder_word = '0;
      held_symbols   = '0;
      held_count     = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[k]) begin
         if (k % 7 == 0) begin
            src_quiet = ($urandom_range(0, 2) == 0);
            snk_quiet = ($urandom_range(0, 2) == 0);
         end
         send_symbol(DIRECTED[k].symbol, DIRECTED[k].last_symbol, DIRECTED[k].fixed,
                     '{checksum: DIRECTED[k].checksum,
                       short_message: DIRECTED[k].short_message});
      end

      phase_gens[0] = 30'h3fffffff;
      phase_gens[1] = 30'h00000001;
      phase_gens[2] = check_word_type'($urandom);
      phase_gens[3] = 30'h20000000;
      phase_gens[4] = check_word_type'($urandom);
      phase_gens[5] = 30'h00000000;

      foreach (phase_gens[p]) begin
         wait_drained();
         write_generator(phase_gens[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // switch between busy stretches and idle-heavy stretches now and then
            if ($urandom_range(0, 3) == 0) begin
               src_quiet = ($urandom_range(0, 2) == 0);
               snk_quiet = ($urandom_range(0, 2) == 0);
            end
            len = pick_length();
            for (int s = 0; s < len; s++)
               send_symbol(pick_symbol(), s == len - 1, 1'b0, none);
            sent += len;
         end
      end

      wait_drained();
      if (pending_sums.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
